/* rtl/cdq_pkg.sv */
package cdq_pkg;

   localparam int ACT_W = 3;
   localparam int CNT_W = 7;

   localparam logic [ACT_W-1:0] ACT_PUSH_NEWEST = 3'd0;
   localparam logic [ACT_W-1:0] ACT_PUSH_OLDEST = 3'd1;
   localparam logic [ACT_W-1:0] ACT_DROP_NEWEST = 3'd2;
   localparam logic [ACT_W-1:0] ACT_DROP_OLDEST = 3'd3;
   localparam logic [ACT_W-1:0] ACT_READ_OLDEST = 3'd4;
   localparam logic [ACT_W-1:0] ACT_READ_NEWEST = 3'd5;

   localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

   typedef struct packed {
      logic             status;
      logic             rd_ok;
      logic [CNT_W-1:0] dropped;
      logic [CNT_W-1:0] fill;
   } s1_type;

endpackage

/* rtl/cdq_ram.sv */
module cdq_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32,
   parameter int AW    = 6
) (
   input  logic             clock,
   input  logic             we,
   input  logic             re,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/circular_deque_top.sv */
// Double-ended ring buffer held in one single-port synchronous memory.
// rsp_tvalid rises after the request passes the s1 register and the response register
// (pointers and memory are accessed on acceptance, and the read word is registered).
// One transaction per cycle if rsp_tready holds; each request touches at most one slot.
// Reset (synchronous): capacity returns to 64, fill and both pointers go to zero;
// the slot memory is not cleared and no clearing pass is needed.
module circular_deque_top #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // data_in, count_or_index, zero pad
   input  logic [((DATA_WIDTH+cdq_pkg::CNT_W+7)/8)*8-1:0] req_tdata,
   // action
   input  logic [cdq_pkg::ACT_W-1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // read_data, dropped, fill, zero pad
   output logic [((DATA_WIDTH+2*cdq_pkg::CNT_W+7)/8)*8-1:0] rsp_tdata,
   // status
   output logic [0:0] rsp_tuser,
   input  logic csr_wr_en,
   input  logic [cdq_pkg::CNT_W-1:0] csr_wr_data
);
   import cdq_pkg::*;

   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW    = ((AW > CNT_W) ? AW : CNT_W) + 1;
   localparam int OUT_W = ((DATA_WIDTH + 2*CNT_W + 7) / 8) * 8;
   localparam int PAD_W = OUT_W - DATA_WIDTH - 2*CNT_W;

   logic [CNT_W-1:0]      cap_ff;
   logic [AW-1:0]         newest_ff, newest_in;
   logic [AW-1:0]         oldest_ff, oldest_in;
   logic [CNT_W-1:0]      held_ff, held_in;
   logic                  s1_valid_ff;
   s1_type                s1_ff, s1_in;
   logic                  rsp_valid_ff;
   logic [DATA_WIDTH-1:0] rsp_data_ff;
   logic [CNT_W-1:0]      rsp_dropped_ff;
   logic [CNT_W-1:0]      rsp_fill_ff;
   logic                  rsp_status_ff;

   logic [ACT_W-1:0]      act;
   logic [DATA_WIDTH-1:0] din;
   logic [CNT_W-1:0]      n;
   logic                  accept;
   logic                  out_free;
   logic                  s1_adv;
   logic [SW-1:0]         cap_w, c, h, nw, pn, po, k, kk, sum, idx;
   logic                  ram_we, ram_re;
   logic [AW-1:0]         ram_addr;
   logic [DATA_WIDTH-1:0] ram_rdata;

   assign act = req_tuser;
   assign din = req_tdata[DATA_WIDTH-1:0];
   assign n   = req_tdata[DATA_WIDTH +: CNT_W];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;

   // A capacity of zero acts as one; anything above the storage depth acts as the depth.
   assign cap_w = SW'(cap_ff);
   assign c     = (cap_w == '0) ? SW'(1) : ((cap_w > SW'(DEPTH)) ? SW'(DEPTH) : cap_w);
   assign h     = SW'(held_ff);
   assign nw    = SW'(n);
   assign pn    = SW'(newest_ff);
   assign po    = SW'(oldest_ff);
   assign k     = (nw < h) ? nw : h;
   assign kk    = (k == c) ? '0 : k;

   always_comb begin
      newest_in  = newest_ff;
      oldest_in  = oldest_ff;
      held_in    = held_ff;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      ram_addr   = newest_ff;
      sum        = '0;
      idx        = '0;
      s1_in      = '0;
      case (act)
         ACT_PUSH_NEWEST: begin
            if (h >= c) begin
               s1_in.status = 1'b1;
            end else begin
               ram_we    = accept;
               ram_addr  = newest_ff;
               sum       = pn + SW'(1);
               newest_in = AW'((sum >= c) ? sum - c : sum);
               held_in   = held_ff + CNT_W'(1);
            end
         end
         ACT_PUSH_OLDEST: begin
            if (h >= c) begin
               s1_in.status = 1'b1;
            end else begin
               sum       = (po == '0) ? c - SW'(1) : po - SW'(1);
               ram_we    = accept;
               ram_addr  = AW'(sum);
               oldest_in = AW'(sum);
               held_in   = held_ff + CNT_W'(1);
            end
         end
         ACT_DROP_NEWEST: begin
            newest_in     = AW'((pn >= k) ? pn - k : pn + c - k);
            held_in       = held_ff - CNT_W'(k);
            s1_in.dropped = CNT_W'(k);
         end
         ACT_DROP_OLDEST: begin
            // Dropping a full ring leaves the oldest pointer where it is.
            sum           = po + kk;
            oldest_in     = AW'((sum >= c) ? sum - c : sum);
            held_in       = held_ff - CNT_W'(k);
            s1_in.dropped = CNT_W'(k);
         end
         ACT_READ_OLDEST, ACT_READ_NEWEST: begin
            if (nw >= h) begin
               s1_in.status = 1'b1;
            end else begin
               idx         = (act == ACT_READ_OLDEST) ? nw : h - nw - SW'(1);
               sum         = po + idx;
               ram_addr    = AW'((sum >= c) ? sum - c : sum);
               ram_re      = accept;
               s1_in.rd_ok = 1'b1;
            end
         end
         default: begin
            s1_in.status = 1'b1;
         end
      endcase
      s1_in.fill = held_in;
   end

   cdq_ram #(
      .DEPTH (DEPTH),
      .WIDTH (DATA_WIDTH),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (din),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         newest_ff    <= '0;
         oldest_ff    <= '0;
         held_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff    <= csr_wr_data;
            newest_ff <= '0;
            oldest_ff <= '0;
            held_ff   <= '0;
         end else if (accept) begin
            newest_ff <= newest_in;
            oldest_ff <= oldest_in;
            held_ff   <= held_in;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      if (s1_adv) begin
         rsp_status_ff  <= s1_ff.status;
         rsp_dropped_ff <= s1_ff.dropped;
         rsp_fill_ff    <= s1_ff.fill;
         rsp_data_ff    <= s1_ff.rd_ok ? ram_rdata : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_fill_ff, rsp_dropped_ff, rsp_data_ff};

endmodule

/* verif/tb_circular_deque_top.sv */
`timescale 1ns / 1ps

module tb_circular_deque_top;
   import cdq_pkg::*;

   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;
   localparam int SLOT_W     = $clog2(DEPTH);
   localparam int REQ_W      = ((DATA_WIDTH + CNT_W + 7) / 8) * 8;
   localparam int RSP_W      = ((DATA_WIDTH + 2 * CNT_W + 7) / 8) * 8;

   localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
   localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;
   localparam logic STAT_OK  = 1'b0;
   localparam logic STAT_ERR = 1'b1;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int ITEMS_PER_PASS = 142;
   localparam int DRAIN_CYCLES   = 8;

   typedef struct packed {
      logic                  status;
      logic [DATA_WIDTH-1:0] read_data;
      logic [CNT_W-1:0]      dropped;
      logic [CNT_W-1:0]      fill;
   } deque_rsp_type;

   typedef struct {
      logic [ACT_W-1:0]      act;
      logic [DATA_WIDTH-1:0] word;
      logic [CNT_W-1:0]      n;
      bit                    typed;
      deque_rsp_type         want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic [ACT_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_wr_en = 1'b0;
   logic [CNT_W-1:0] csr_wr_data = '0;

   // Shadow copy of the ring used to predict every response.
   logic [DATA_WIDTH-1:0] ring_words [DEPTH];
   int unsigned newest_slot;
   int unsigned oldest_slot;
   int unsigned words_held;
   int unsigned capacity_reg;

   deque_rsp_type results_due [$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned req_idle_pct = 34;
   int unsigned rsp_idle_pct = 85;

   // The rows with a typed-in response are the ones whose outcome is obvious:
   // empty-deque errors, drops on an empty deque, spare actions, the first two pushes and bad indexes.
   localparam int N_DIR = 22;
   dir_row_type dir_rows [N_DIR] = '{
      '{ACT_READ_OLDEST, 32'h0000_0000, 7'd0,   1'b1, '{STAT_ERR, 32'h0, 7'd0, 7'd0}},
      '{ACT_READ_NEWEST, 32'hFFFF_FFFF, 7'd0,   1'b1, '{STAT_ERR, 32'h0, 7'd0, 7'd0}},
      '{ACT_DROP_NEWEST, 32'h0000_0000, 7'd5,   1'b1, '{STAT_OK,  32'h0, 7'd0, 7'd0}},
      '{ACT_DROP_OLDEST, 32'h0000_0000, 7'd127, 1'b1, '{STAT_OK,  32'h0, 7'd0, 7'd0}},
      '{ACT_SPARE_6,     32'h1234_5678, 7'd1,   1'b1, '{STAT_ERR, 32'h0, 7'd0, 7'd0}},
      '{ACT_SPARE_7,     32'hFFFF_FFFF, 7'd127, 1'b1, '{STAT_ERR, 32'h0, 7'd0, 7'd0}},
      '{ACT_PUSH_NEWEST, 32'hFFFF_FFFF, 7'd127, 1'b1, '{STAT_OK,  32'h0, 7'd0, 7'd1}},
      '{ACT_PUSH_OLDEST, 32'h0000_0000, 7'd0,   1'b1, '{STAT_OK,  32'h0, 7'd0, 7'd2}},
      '{ACT_PUSH_NEWEST, 32'hA5A5_A5A5, 7'd0,   1'b0, '0},
      '{ACT_READ_OLDEST, 32'h0000_0000, 7'd0,   1'b0, '0},
      '{ACT_READ_NEWEST, 32'h0000_0000, 7'd0,   1'b0, '0},
      '{ACT_READ_OLDEST, 32'h0000_0000, 7'd2,   1'b0, '0},
      '{ACT_READ_NEWEST, 32'h0000_0000, 7'd2,   1'b0, '0},
      '{ACT_READ_OLDEST, 32'h0000_0000, 7'd3,   1'b1, '{STAT_ERR, 32'h0, 7'd0, 7'd3}},
      '{ACT_READ_NEWEST, 32'h0000_0000, 7'd127, 1'b1, '{STAT_ERR, 32'h0, 7'd0, 7'd3}},
      '{ACT_SPARE_7,     32'h0000_0000, 7'd0,   1'b1, '{STAT_ERR, 32'h0, 7'd0, 7'd3}},
      '{ACT_PUSH_OLDEST, 32'h5A5A_5A5A, 7'd64,  1'b0, '0},
      '{ACT_READ_NEWEST, 32'h0000_0000, 7'd3,   1'b0, '0},
      '{ACT_DROP_OLDEST, 32'h0000_0000, 7'd1,   1'b0, '0},
      '{ACT_DROP_NEWEST, 32'h0000_0000, 7'd1,   1'b0, '0},
      '{ACT_READ_NEWEST, 32'h0000_0000, 7'd0,   1'b0, '0},
      '{ACT_DROP_OLDEST, 32'h0000_0000, 7'd64,  1'b0, '0}
   };

   logic [CNT_W-1:0] capacity_plan [12] = '{
      7'd1, 7'd0, 7'd127, 7'd2, 7'd64, 7'd3, 7'd65, 7'd5, 7'd16, 7'd63, 7'd1, 7'd8
   };

   circular_deque_top #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   function automatic void empty_ring();
      newest_slot = 0;
      oldest_slot = 0;
      words_held = 0;
   endfunction

   function automatic deque_rsp_type apply_deque_op(logic [ACT_W-1:0] act,
                                                    logic [DATA_WIDTH-1:0] word,
                                                    logic [CNT_W-1:0] n);
      int unsigned ring;
      int unsigned cnt;
      int unsigned k;
      int unsigned pos;
      deque_rsp_type r;
      ring = (capacity_reg == 0) ? 1 : ((capacity_reg > DEPTH) ? DEPTH : capacity_reg);
      cnt = 32'(n);
      r = '0;
      case (act)
         ACT_PUSH_NEWEST: begin
            if (words_held >= ring) begin
               r.status = STAT_ERR;
            end else begin
               ring_words[SLOT_W'(newest_slot)] = word;
               newest_slot = (newest_slot + 1) % ring;
               words_held++;
            end
         end
         ACT_PUSH_OLDEST: begin
            if (words_held >= ring) begin
               r.status = STAT_ERR;
            end else begin
               oldest_slot = (oldest_slot + ring - 1) % ring;
               ring_words[SLOT_W'(oldest_slot)] = word;
               words_held++;
            end
         end
         ACT_DROP_NEWEST, ACT_DROP_OLDEST: begin
            k = (cnt < words_held) ? cnt : words_held;
            if (act == ACT_DROP_NEWEST) begin
               newest_slot = (newest_slot + ring - k) % ring;
            end else begin
               oldest_slot = (oldest_slot + k) % ring;
            end
            words_held -= k;
            r.dropped = k[CNT_W-1:0];
         end
         ACT_READ_OLDEST, ACT_READ_NEWEST: begin
            if (cnt >= words_held) begin
               r.status = STAT_ERR;
            end else begin
               // Position from the newest end maps to fill - n - 1 from the oldest.
               pos = (act == ACT_READ_OLDEST) ? cnt : words_held - cnt - 1;
               r.read_data = ring_words[SLOT_W'((oldest_slot + pos) % ring)];
            end
         end
         default: begin
            r.status = STAT_ERR;
         end
      endcase
      r.fill = words_held[CNT_W-1:0];
      return r;
   endfunction

   task automatic send_request(logic [ACT_W-1:0] act, logic [DATA_WIDTH-1:0] word,
                               logic [CNT_W-1:0] n, bit typed, deque_rsp_type want);
      deque_rsp_type predicted;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {{(REQ_W - DATA_WIDTH - CNT_W){1'b0}}, n, word};
      do @(posedge clock); while (!req_tready);
      predicted = apply_deque_op(act, word, n);
      results_due.push_back(typed ? want : predicted);
   endtask

   // Capacity is only changed with the deque idle and every response drained.
   task automatic write_capacity(logic [CNT_W-1:0] value);
      req_tvalid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      capacity_reg = 32'(value);
      empty_ring();
   endtask

   task automatic send_random_request(int unsigned push_weight);
      int unsigned pick;
      logic [ACT_W-1:0] act;
      logic [CNT_W-1:0] n;
      pick = $urandom_range(0, 99);
      if (pick < push_weight) begin
         act = ($urandom_range(0, 1) == 0) ? ACT_PUSH_NEWEST : ACT_PUSH_OLDEST;
         n = CNT_W'($urandom_range(0, 127));
      end else if (pick < push_weight + 20) begin
         act = ($urandom_range(0, 1) == 0) ? ACT_DROP_NEWEST : ACT_DROP_OLDEST;
         n = CNT_W'(($urandom_range(0, 99) < 80) ? $urandom_range(0, 3)
                                                 : $urandom_range(0, 127));
      end else if (pick < 96) begin
         act = ($urandom_range(0, 1) == 0) ? ACT_READ_OLDEST : ACT_READ_NEWEST;
         if (words_held > 0 && $urandom_range(0, 99) < 85) begin
            n = CNT_W'($urandom_range(0, words_held - 1));
         end else begin
            n = CNT_W'($urandom_range(0, 127));
         end
      end else begin
         act = ($urandom_range(0, 1) == 0) ? ACT_SPARE_6 : ACT_SPARE_7;
         n = CNT_W'($urandom_range(0, 127));
      end
      send_request(act, $urandom, n, 1'b0, '0);
   endtask

   task automatic report_mismatch(string what, deque_rsp_type want, deque_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s: expected status=%0d data=%h dropped=%0d fill=%0d,",
                  what, want.status, want.read_data, want.dropped, want.fill);
         $display("   got status=%0d data=%h dropped=%0d fill=%0d",
                  got.status, got.read_data, got.dropped, got.fill);
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   always @(posedge clock) begin
      deque_rsp_type got;
      deque_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status = rsp_tuser[0];
         got.read_data = rsp_tdata[DATA_WIDTH-1:0];
         got.dropped = rsp_tdata[DATA_WIDTH +: CNT_W];
         got.fill = rsp_tdata[DATA_WIDTH + CNT_W +: CNT_W];
         if (results_due.size() == 0) begin
            report_mismatch("unexpected transaction", '0, got);
         end else begin
            want = results_due.pop_front();
            if (got.status !== want.status || got.read_data !== want.read_data ||
                got.dropped !== want.dropped || got.fill !== want.fill) begin
               report_mismatch("response mismatch", want, got);
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      capacity_reg = 32'(CAP_RESET);
      empty_ring();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         send_request(dir_rows[i].act, dir_rows[i].word, dir_rows[i].n,
                      dir_rows[i].typed, dir_rows[i].want);
      end

      for (int pass = 0; pass < 12; pass++) begin
         write_capacity(capacity_plan[4'(pass)]);
         // Four passes per idling scheme: slow receiver, then slow sender, then none.
         case (pass / 4)
            0: begin req_idle_pct = 34; rsp_idle_pct = 85; end
            1: begin req_idle_pct = 85; rsp_idle_pct = 34; end
            default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         for (int i = 0; i < ITEMS_PER_PASS; i++) begin
            send_random_request((pass % 2 == 0) ? 65 : 40);
         end
      end
      req_tvalid <= 1'b0;

      while (results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && results_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/cdq_pkg.sv
rtl/cdq_ram.sv
rtl/circular_deque_top.sv
verif/tb_circular_deque_top.sv
